/* src/lffc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lffc_pkg
// Shared widths, reset values and register indexes of the LED follow/fade core.
// ----------------------------------------------------------------------------
package lffc_pkg;

	localparam int LEVEL_W    = 8;
	localparam int OFF_W      = 16;
	localparam int TICK_W     = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST   = 8'd10;
	localparam logic [OFF_W-1:0]   OFF_DELAY_RST   = 16'd3000;
	localparam logic [TICK_W-1:0]  FADE_PERIOD_RST = 8'd20;
	localparam logic [TICK_W-1:0]  POLL_PERIOD_RST = 8'd10;
	localparam logic [LEVEL_W-1:0] SEEN_LEVEL_RST  = 8'd255;
	localparam logic [LEVEL_W-1:0] VALID_LEVEL_RST = 8'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_LEVEL   = 2'd0,
		CFG_OFF_DELAY   = 2'd1,
		CFG_FADE_PERIOD = 2'd2,
		CFG_POLL_PERIOD = 2'd3
	} cfg_reg_t;

endpackage

/* src/lffc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lffc_in_if / lffc_out_if
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface lffc_in_if;
	logic                             valid;
	logic                             ready;
	logic [lffc_pkg::LEVEL_W-1:0]     backlight_level;

	modport source (output valid, output backlight_level, input ready);
	modport sink   (input valid, input backlight_level, output ready);
endinterface

interface lffc_out_if;
	logic                             valid;
	logic                             ready;
	logic [lffc_pkg::LEVEL_W-1:0]     led_drive;
	logic [lffc_pkg::LEVEL_W-1:0]     last_valid_level;
	logic                             fading;

	modport source (output valid, output led_drive, output last_valid_level,
		output fading, input ready);
	modport sink   (input valid, input led_drive, input last_valid_level,
		input fading, output ready);
endinterface

/* src/led_follow_fade_controller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_follow_fade_controller_core
// Follows the backlight level on the LEDs, with fade-in and auto-off fade-out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer per millisecond tick, carrying backlight_level.
//   out_ch : one transfer per tick: led_drive, last_valid_level, fading.
//   wr_*   : register writes (min level, off delay, fade period, poll
//            period), only while no tick is in flight.
// A tick taken at an edge shows on out_ch after it. Throughput is one tick
// per cycle while out_ch is ready; the whole tick update (poll, auto-off,
// one fade step with its 8 x 24 bit multiply) is a single pass of logic
// from the state registers into the result register.
// in_ch.ready is high while the result register is empty or being taken,
// so a stalled receiver holds the result and stops new ticks until it
// takes it; nothing is dropped.
// Reset loads the tick state and registers with reset values; the first
// tick after reset drives the clamped level at once and arms the off timer.
// ----------------------------------------------------------------------------
module led_follow_fade_controller_core #(
	parameter int FADE_STEP_COUNT = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	lffc_in_if.sink                             in_ch,
	lffc_out_if.source                          out_ch,
	input  logic                                wr_en,
	input  logic [lffc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [lffc_pkg::CFG_DATA_W-1:0]     wr_data
);

	localparam int LW     = lffc_pkg::LEVEL_W;
	localparam int OW     = lffc_pkg::OFF_W;
	localparam int TW     = lffc_pkg::TICK_W;
	localparam int IDX_W  = $clog2(FADE_STEP_COUNT + 1);
	localparam int SHIFT  = 8 + 2 * IDX_W;
	localparam longint RECIP = ((64'd1 << SHIFT) + FADE_STEP_COUNT - 1) / FADE_STEP_COUNT;
	localparam int COEF_W = SHIFT + 1 + IDX_W;
	localparam int PROD_W = LW + COEF_W;

	// k * ceil(2^SHIFT / N): with |diff| * N^2 < 2^SHIFT the shifted product
	// equals floor(|diff| * k / N) exactly
	typedef logic [2**IDX_W-1:0][COEF_W-1:0] coef_tab_t;

	function automatic coef_tab_t build_coef();
		coef_tab_t tab;
		for (int k = 0; k < 2**IDX_W; k++) begin
			tab[k] = COEF_W'(longint'(k) * RECIP);
		end
		return tab;
	endfunction

	localparam coef_tab_t COEF = build_coef();

	// configuration
	logic [LW-1:0] min_level_q;
	logic [OW-1:0] off_delay_q;
	logic [TW-1:0] fade_period_q;
	logic [TW-1:0] poll_period_q;

	// tick state
	logic [LW-1:0]    seen_level_q, drive_level_q, fade_target_q, valid_level_q;
	logic [IDX_W-1:0] fade_index_q;
	logic             fade_active_q, off_armed_q, started_q;
	logic [TW-1:0]    fade_timer_q, poll_timer_q;
	logic [OW-1:0]    off_timer_q;

	// result register
	logic          out_valid_q;
	logic [LW-1:0] led_drive_q, last_valid_q;
	logic          fading_q;

	logic accept;

	// next state
	logic [LW-1:0]    seen_n, drive_n, target_n, valid_n;
	logic [IDX_W-1:0] index_n;
	logic             active_n, armed_n, off_fresh, fade_fresh;
	logic [TW-1:0]    fade_timer_n, poll_timer_n;
	logic [OW-1:0]    off_timer_n;
	logic [LW-1:0]    lvl, diff_mag, q_mag;
	logic             diff_neg;
	logic [PROD_W-1:0] prod;

	function automatic logic [LW-1:0] clamp_level(input logic [LW-1:0] b,
		input logic [LW-1:0] floor_lvl);
		logic [LW-1:0] r;
		if (b == '0) r = '0;
		else if (b < floor_lvl) r = floor_lvl;
		else r = b;
		return r;
	endfunction

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		seen_n       = seen_level_q;
		drive_n      = drive_level_q;
		target_n     = fade_target_q;
		valid_n      = valid_level_q;
		index_n      = fade_index_q;
		active_n     = fade_active_q;
		armed_n      = off_armed_q;
		fade_timer_n = fade_timer_q;
		poll_timer_n = poll_timer_q;
		off_timer_n  = off_timer_q;
		off_fresh    = 1'b0;
		fade_fresh   = 1'b0;
		diff_mag     = '0;
		diff_neg     = 1'b0;
		prod         = '0;
		q_mag        = '0;

		lvl = clamp_level(in_ch.backlight_level, min_level_q);

		if (!started_q) begin
			if (lvl != '0) valid_n = lvl;
			drive_n      = lvl;
			off_timer_n  = off_delay_q;
			armed_n      = 1'b1;
			off_fresh    = 1'b1;
			poll_timer_n = '0;
		end

		// poll
		if (poll_timer_n == '0) begin
			if (in_ch.backlight_level != seen_n) begin
				seen_n = in_ch.backlight_level;
				if (lvl != '0) begin
					valid_n = lvl;
					if (drive_n == '0) begin
						target_n     = lvl;
						index_n      = '0;
						active_n     = 1'b1;
						fade_timer_n = fade_period_q;
						fade_fresh   = 1'b1;
					end else begin
						drive_n = lvl;
					end
				end
				off_timer_n = off_delay_q;
				armed_n     = 1'b1;
				off_fresh   = 1'b1;
			end
			poll_timer_n = (poll_period_q == '0) ? '0 : poll_period_q - 1'b1;
		end else begin
			poll_timer_n = poll_timer_n - 1'b1;
		end

		// auto-off
		if (armed_n && !off_fresh) begin
			if (off_timer_n <= OW'(1)) begin
				armed_n      = 1'b0;
				off_timer_n  = '0;
				target_n     = '0;
				index_n      = '0;
				active_n     = 1'b1;
				fade_timer_n = fade_period_q;
				fade_fresh   = 1'b1;
			end else begin
				off_timer_n = off_timer_n - 1'b1;
			end
		end

		// fade step: drive += trunc((target - drive) * k / N)
		if (active_n && !fade_fresh) begin
			if (fade_timer_n <= TW'(1)) begin
				diff_neg = target_n < drive_n;
				diff_mag = diff_neg ? drive_n - target_n : target_n - drive_n;
				prod     = PROD_W'(diff_mag) * PROD_W'(COEF[index_n]);
				q_mag    = prod[SHIFT +: LW];
				drive_n  = diff_neg ? drive_n - q_mag : drive_n + q_mag;
				if ({1'b0, index_n} + 1'b1 > (IDX_W+1)'(FADE_STEP_COUNT)) begin
					drive_n  = target_n;
					active_n = 1'b0;
					index_n  = '0;
				end else begin
					index_n      = index_n + 1'b1;
					fade_timer_n = fade_period_q;
				end
			end else begin
				fade_timer_n = fade_timer_n - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q   <= lffc_pkg::MIN_LEVEL_RST;
			off_delay_q   <= lffc_pkg::OFF_DELAY_RST;
			fade_period_q <= lffc_pkg::FADE_PERIOD_RST;
			poll_period_q <= lffc_pkg::POLL_PERIOD_RST;
		end else if (wr_en) begin
			unique case (lffc_pkg::cfg_reg_t'(wr_index))
				lffc_pkg::CFG_MIN_LEVEL:   min_level_q   <= wr_data[LW-1:0];
				lffc_pkg::CFG_OFF_DELAY:   off_delay_q   <= wr_data[OW-1:0];
				lffc_pkg::CFG_FADE_PERIOD: fade_period_q <= wr_data[TW-1:0];
				lffc_pkg::CFG_POLL_PERIOD: poll_period_q <= wr_data[TW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_level_q  <= lffc_pkg::SEEN_LEVEL_RST;
			drive_level_q <= '0;
			fade_target_q <= '0;
			valid_level_q <= lffc_pkg::VALID_LEVEL_RST;
			fade_index_q  <= '0;
			fade_active_q <= 1'b0;
			off_armed_q   <= 1'b0;
			started_q     <= 1'b0;
			fade_timer_q  <= '0;
			poll_timer_q  <= '0;
			off_timer_q   <= '0;
		end else if (accept) begin
			seen_level_q  <= seen_n;
			drive_level_q <= drive_n;
			fade_target_q <= target_n;
			valid_level_q <= valid_n;
			fade_index_q  <= index_n;
			fade_active_q <= active_n;
			off_armed_q   <= armed_n;
			started_q     <= 1'b1;
			fade_timer_q  <= fade_timer_n;
			poll_timer_q  <= poll_timer_n;
			off_timer_q   <= off_timer_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			led_drive_q  <= drive_n;
			last_valid_q <= valid_n;
			fading_q     <= active_n;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.led_drive        = led_drive_q;
	assign out_ch.last_valid_level = last_valid_q;
	assign out_ch.fading           = fading_q;

	// the step index rests at zero whenever no fade runs
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!fade_active_q |-> fade_index_q == '0)
		else $error("fade index not cleared while idle");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		fade_index_q <= IDX_W'(FADE_STEP_COUNT))
		else $error("fade index beyond step count");

	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q && led_drive_q == $past(drive_n))
		else $error("accepted tick gave no result");

	a_started_stays: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("started flag dropped");

endmodule

/* tb/lffc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lffc_checker
// Watches the tick and result channels and the register port of the LED
// follow/fade core. Keeps its own copy of the tick behaviour, queues the
// expected result of every tick transfer and compares each result transfer
// with the oldest one waiting.
// ----------------------------------------------------------------------------
module lffc_checker #(
	parameter int FADE_STEP_COUNT = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lffc_in_if                              in_mon,
	lffc_out_if                             out_mon,
	input  logic                            wr_en,
	input  logic [lffc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [lffc_pkg::CFG_DATA_W-1:0] wr_data,
	output int                              mismatches,
	output int                              results_owed
);

	localparam int LEVEL_W = lffc_pkg::LEVEL_W;
	localparam int OFF_W   = lffc_pkg::OFF_W;
	localparam int TICK_W  = lffc_pkg::TICK_W;

	typedef struct packed {
		logic [LEVEL_W-1:0] led_drive;
		logic [LEVEL_W-1:0] last_valid_level;
		logic               fading;
	} led_result_t;

	led_result_t led_result_q[$];

	// register copies
	logic [LEVEL_W-1:0] min_lvl;
	logic [OFF_W-1:0]   off_delay;
	logic [TICK_W-1:0]  fade_period;
	logic [TICK_W-1:0]  poll_period;

	// tick state
	logic [LEVEL_W-1:0] seen_lvl;
	logic [LEVEL_W-1:0] drive_lvl;
	logic [LEVEL_W-1:0] fade_target;
	logic [4:0]         fade_idx;
	logic               fade_on;
	logic [TICK_W-1:0]  fade_cnt;
	logic [OFF_W-1:0]   off_cnt;
	logic               off_armed;
	logic [TICK_W-1:0]  poll_cnt;
	logic [LEVEL_W-1:0] valid_lvl;
	logic               started;
	logic               fade_fresh;

	function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] b);
		if (b == '0)
			return '0;
		return (b < min_lvl) ? min_lvl : b;
	endfunction

	task automatic begin_fade(input logic [LEVEL_W-1:0] target);
		fade_target = target;
		fade_idx = '0;
		fade_on = 1'b1;
		fade_cnt = fade_period;
		fade_fresh = 1'b1;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: MISMATCH %s", $time, msg);
		mismatches++;
	endtask

	// One tick: poll, then auto-off, then one fade step; returns the new outputs.
	task automatic advance_tick(input logic [LEVEL_W-1:0] b, output led_result_t res);
		logic [LEVEL_W-1:0] lvl;
		logic               off_fresh;
		int                 diff;
		int                 quot;
		off_fresh = 1'b0;
		fade_fresh = 1'b0;
		if (!started) begin
			lvl = clamp_level(b);
			started = 1'b1;
			if (lvl != '0)
				valid_lvl = lvl;
			drive_lvl = lvl;
			off_cnt = off_delay;
			off_armed = 1'b1;
			off_fresh = 1'b1;
			poll_cnt = '0;
		end
		if (poll_cnt == '0) begin
			if (b != seen_lvl) begin
				seen_lvl = b;
				lvl = clamp_level(b);
				if (lvl != '0) begin
					valid_lvl = lvl;
					if (drive_lvl == '0)
						begin_fade(lvl);
					else
						drive_lvl = lvl;
				end
				off_cnt = off_delay;
				off_armed = 1'b1;
				off_fresh = 1'b1;
			end
			poll_cnt = (poll_period == '0) ? '0 : poll_period - 8'd1;
		end else begin
			poll_cnt = poll_cnt - 8'd1;
		end
		if (off_armed && !off_fresh) begin
			if (off_cnt <= 16'd1) begin
				off_armed = 1'b0;
				off_cnt = '0;
				begin_fade('0);
			end else begin
				off_cnt = off_cnt - 16'd1;
			end
		end
		if (fade_on && !fade_fresh) begin
			if (fade_cnt <= 8'd1) begin
				diff = int'(fade_target) - int'(drive_lvl);
				quot = (diff * int'(fade_idx)) / FADE_STEP_COUNT;
				drive_lvl = 8'(int'(drive_lvl) + quot);
				if (int'(fade_idx) + 1 > FADE_STEP_COUNT) begin
					drive_lvl = fade_target;
					fade_on = 1'b0;
					fade_idx = '0;
				end else begin
					fade_idx = fade_idx + 5'd1;
					fade_cnt = fade_period;
				end
			end else begin
				fade_cnt = fade_cnt - 8'd1;
			end
		end
		res.led_drive = drive_lvl;
		res.last_valid_level = valid_lvl;
		res.fading = fade_on;
	endtask

	always @(posedge clk or negedge arst_n) begin
		led_result_t got;
		led_result_t want;
		if (!arst_n) begin
			led_result_q.delete();
			min_lvl = lffc_pkg::MIN_LEVEL_RST;
			off_delay = lffc_pkg::OFF_DELAY_RST;
			fade_period = lffc_pkg::FADE_PERIOD_RST;
			poll_period = lffc_pkg::POLL_PERIOD_RST;
			seen_lvl = lffc_pkg::SEEN_LEVEL_RST;
			drive_lvl = '0;
			fade_target = '0;
			fade_idx = '0;
			fade_on = 1'b0;
			fade_cnt = '0;
			off_cnt = '0;
			off_armed = 1'b0;
			poll_cnt = '0;
			valid_lvl = lffc_pkg::VALID_LEVEL_RST;
			started = 1'b0;
			fade_fresh = 1'b0;
			results_owed = 0;
		end else begin
			// results first: a result never belongs to a tick taken at the same edge
			if (out_mon.valid && out_mon.ready) begin
				got.led_drive = out_mon.led_drive;
				got.last_valid_level = out_mon.last_valid_level;
				got.fading = out_mon.fading;
				if (led_result_q.size() == 0) begin
					report_mismatch($sformatf(
						"result with no tick waiting: led %0d valid %0d fading %0d",
						got.led_drive, got.last_valid_level, got.fading));
				end else begin
					want = led_result_q.pop_front();
					if (got.led_drive !== want.led_drive)
						report_mismatch($sformatf("led_drive got %0d want %0d",
							got.led_drive, want.led_drive));
					if (got.last_valid_level !== want.last_valid_level)
						report_mismatch($sformatf("last_valid_level got %0d want %0d",
							got.last_valid_level, want.last_valid_level));
					if (got.fading !== want.fading)
						report_mismatch($sformatf("fading got %0d want %0d",
							got.fading, want.fading));
				end
			end
			// a tick at the same edge as a write still sees the old register value
			if (in_mon.valid && in_mon.ready) begin
				advance_tick(in_mon.backlight_level, want);
				led_result_q.push_back(want);
			end
			if (wr_en) begin
				case (lffc_pkg::cfg_reg_t'(wr_index))
					lffc_pkg::CFG_MIN_LEVEL:   min_lvl = wr_data[LEVEL_W-1:0];
					lffc_pkg::CFG_OFF_DELAY:   off_delay = wr_data[OFF_W-1:0];
					lffc_pkg::CFG_FADE_PERIOD: fade_period = wr_data[TICK_W-1:0];
					lffc_pkg::CFG_POLL_PERIOD: poll_period = wr_data[TICK_W-1:0];
					default: ;
				endcase
			end
			results_owed = led_result_q.size();
		end
	end

	initial mismatches = 0;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the LED follow/fade core: directed ticks at the register
// extremes, then random backlight sequences under several register settings
// and three idle patterns on the tick and result channels. The checker
// beside the core does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

	localparam int STEP_COUNT    = 20;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 60;
	localparam int TICKS_PER_SET = 104;

	logic                            clk;
	logic                            arst_n;
	logic                            wr_en;
	logic [lffc_pkg::CFG_IDX_W-1:0]  wr_index;
	logic [lffc_pkg::CFG_DATA_W-1:0] wr_data;

	int mismatches;
	int results_owed;
	int cycle_count = 0;
	int send_idle_pct = 29;
	int recv_idle_pct = 83;
	int change_pct = 5;
	int hold_requests = 0;
	logic [lffc_pkg::LEVEL_W-1:0] steady_level = 8'd0;

	lffc_in_if  in_ch();
	lffc_out_if out_ch();

	led_follow_fade_controller_core #(
		.FADE_STEP_COUNT(STEP_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	lffc_checker #(
		.FADE_STEP_COUNT(STEP_COUNT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.mismatches(mismatches),
		.results_owed(results_owed)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin
		int hold_left;
		int holds_taken;
		hold_left = 0;
		holds_taken = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_taken) begin
				holds_taken = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_tick(input logic [lffc_pkg::LEVEL_W-1:0] level);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			in_ch.backlight_level = 8'($urandom_range(255));
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.backlight_level = level;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic settle();
		in_ch.valid = 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input lffc_pkg::cfg_reg_t idx,
		input logic [lffc_pkg::CFG_DATA_W-1:0] value);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = value;
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic apply_settings(input int min_lvl, input int off_delay,
		input int fade_period, input int poll_period);
		settle();
		write_reg(lffc_pkg::CFG_MIN_LEVEL, 16'(min_lvl));
		write_reg(lffc_pkg::CFG_OFF_DELAY, 16'(off_delay));
		write_reg(lffc_pkg::CFG_FADE_PERIOD, 16'(fade_period));
		write_reg(lffc_pkg::CFG_POLL_PERIOD, 16'(poll_period));
	endtask

	// mostly a held level that changes now and then, with single-tick glitches
	task automatic send_random_ticks(input int count);
		logic [lffc_pkg::LEVEL_W-1:0] level;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < change_pct) begin
				case ($urandom_range(4))
					0: steady_level = 8'd0;
					1: steady_level = 8'd255;
					2: steady_level = 8'($urandom_range(1, 15));
					default: steady_level = 8'($urandom_range(255));
				endcase
			end
			if ($urandom_range(99) < 4)
				level = 8'($urandom_range(255));
			else
				level = steady_level;
			send_tick(level);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.backlight_level = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// first tick below the floor, at reset settings
		send_tick(8'd3);
		send_tick(8'd255);
		send_tick(8'd0);

		// shortest timers, floor at the top
		apply_settings(255, 1, 1, 1);
		send_tick(8'd1);
		send_tick(8'd0);
		send_tick(8'd128);
		send_tick(8'd128);
		send_tick(8'd0);
		send_tick(8'd255);
		send_tick(8'd255);

		// zero floor and zero periods
		apply_settings(0, 0, 0, 0);
		send_tick(8'd1);
		send_tick(8'd0);
		send_tick(8'd254);
		send_tick(8'd0);
		send_tick(8'd170);
		send_tick(8'd85);
		send_tick(8'd85);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 29; recv_idle_pct = 83; end
				1: begin send_idle_pct = 83; recv_idle_pct = 29; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int set = 0; set < 4; set++) begin
				change_pct = $urandom_range(1, 10);
				if (phase == 0 && set == 0)
					apply_settings(255, 1, 1, 1);
				else if (phase == 2 && set == 3)
					apply_settings(128, 65535, 255, 255);
				else
					apply_settings($urandom_range(255), $urandom_range(1, 60),
						$urandom_range(1, 4), $urandom_range(1, 5));
				if (phase == 0 && set == 1) begin
					// long result stall while ticks keep coming
					send_random_ticks(TICKS_PER_SET / 2);
					hold_requests++;
					send_random_ticks(TICKS_PER_SET - TICKS_PER_SET / 2);
				end else if (phase == 1 && set == 2) begin
					// tick side waits until every result is back
					send_random_ticks(TICKS_PER_SET / 2);
					settle();
					send_random_ticks(TICKS_PER_SET - TICKS_PER_SET / 2);
				end else begin
					send_random_ticks(TICKS_PER_SET);
				end
			end
		end

		settle();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
src/lffc_pkg.sv
src/lffc_if.sv
src/led_follow_fade_controller_core.sv
tb/lffc_checker.sv
tb/tb.sv
